// File: rtl/core/tacs_pkg.sv
// ----------------------------------------------------------------------------
// tacs_pkg
// Shared types and codes for the tiny accumulator CPU step block: request and
// result beats, request codes, run status codes, opcodes and ALU operations.
// ----------------------------------------------------------------------------
package tacs_pkg;

  localparam int unsigned DATA_W    = 8;
  localparam int unsigned ADDR_W    = 8;
  localparam int unsigned MEM_DEPTH = 256;
  localparam int unsigned REG_COUNT = 4;
  localparam int unsigned REG_IDX_W = 2;

  // Request codes
  localparam logic [1:0] REQ_WRITE = 2'd0;
  localparam logic [1:0] REQ_READ  = 2'd1;
  localparam logic [1:0] REQ_EXEC  = 2'd2;

  // Run status codes
  localparam logic [1:0] ST_RUN    = 2'd0;
  localparam logic [1:0] ST_HALT   = 2'd1;
  localparam logic [1:0] ST_BADREG = 2'd2;
  localparam logic [1:0] ST_BADOP  = 2'd3;

  // Opcodes
  localparam logic [7:0] OP_NOP = 8'h00;
  localparam logic [7:0] OP_LDI = 8'h10;
  localparam logic [7:0] OP_MOV = 8'h11;
  localparam logic [7:0] OP_LDM = 8'h12;
  localparam logic [7:0] OP_STM = 8'h13;
  localparam logic [7:0] OP_ADD = 8'h20;
  localparam logic [7:0] OP_SUB = 8'h21;
  localparam logic [7:0] OP_INC = 8'h22;
  localparam logic [7:0] OP_DEC = 8'h23;
  localparam logic [7:0] OP_AND = 8'h24;
  localparam logic [7:0] OP_OR  = 8'h25;
  localparam logic [7:0] OP_XOR = 8'h26;
  localparam logic [7:0] OP_NOT = 8'h27;
  localparam logic [7:0] OP_JMP = 8'h30;
  localparam logic [7:0] OP_JZ  = 8'h31;
  localparam logic [7:0] OP_JNZ = 8'h32;
  localparam logic [7:0] OP_JC  = 8'h33;
  localparam logic [7:0] OP_JNC = 8'h34;
  localparam logic [7:0] OP_HLT = 8'hFF;

  typedef enum logic [2:0] {
    ALU_PASS,
    ALU_ADD,
    ALU_SUB,
    ALU_AND,
    ALU_OR,
    ALU_XOR,
    ALU_NOT
  } alu_op_t;

  typedef struct packed {
    logic [1:0]        req_type;
    logic [ADDR_W-1:0] mem_address;
    logic [DATA_W-1:0] write_byte;
  } req_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [ADDR_W-1:0] program_counter;
    logic [DATA_W-1:0] reg_a;
    logic [DATA_W-1:0] reg_b;
    logic [DATA_W-1:0] reg_c;
    logic [DATA_W-1:0] reg_d;
    logic              zero_flag;
    logic              carry_flag;
    logic [DATA_W-1:0] read_byte;
  } rsp_t;

endpackage

// File: rtl/core/tacs_ram.sv
// ----------------------------------------------------------------------------
// tacs_ram
// Generic single-port RAM with one write or read per cycle and registered
// read data.
// ----------------------------------------------------------------------------
module tacs_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// File: rtl/core/tacs_alu.sv
// ----------------------------------------------------------------------------
// tacs_alu
// Shared 8-bit ALU: add and subtract with carry or borrow out, the logic
// operations and a pass-through for moves.
// ----------------------------------------------------------------------------
module tacs_alu
  import tacs_pkg::*;
(
  input  alu_op_t           op,
  input  logic [DATA_W-1:0] a,
  input  logic [DATA_W-1:0] b,
  output logic [DATA_W-1:0] result,
  output logic              carry
);

  logic [DATA_W:0] sum;
  logic [DATA_W:0] diff;

  assign sum  = {1'b0, a} + {1'b0, b};
  assign diff = {1'b0, a} - {1'b0, b};

  always_comb begin
    result = b;
    carry  = 1'b0;
    case (op)
      ALU_PASS: result = b;
      ALU_ADD: begin
        result = sum[DATA_W-1:0];
        carry  = sum[DATA_W];
      end
      ALU_SUB: begin
        // borrow shows up as the top bit of the widened difference
        result = diff[DATA_W-1:0];
        carry  = diff[DATA_W];
      end
      ALU_AND: result = a & b;
      ALU_OR:  result = a | b;
      ALU_XOR: result = a ^ b;
      ALU_NOT: result = ~a;
      default: result = b;
    endcase
  end

endmodule

// File: rtl/core/tiny_accumulator_cpu_step_top.sv
// ----------------------------------------------------------------------------
// tiny_accumulator_cpu_step_top
// Small 8-bit CPU with four registers, zero and carry flags and a 256-byte
// memory, stepped one request at a time.
// ----------------------------------------------------------------------------
// Usage:
//   Drive a request beat on "request" and raise start while busy is low; the
//   beat is taken at that clock edge. Each request gives exactly one result
//   beat on "result", shown for one cycle with done high. The receiver cannot
//   stall: sample the result in the done cycle.
//   Requests: write a memory byte, read a memory byte, or execute one
//   instruction at the program counter. The result carries the run status,
//   pc, all four registers, both flags and the read byte (zero unless read).
//   Write, a stopped CPU or an unused request code answers straight from
//   idle; read passes S_RD (one RAM read); execute passes S_OP, S_B1, S_B2
//   and S_EXEC, and load from memory adds S_LDM. Over the single RAM port
//   the opcode and two operand bytes are fetched one per cycle, then the
//   shared ALU step runs. busy is low again in the done cycle, so a new
//   start may be taken there.
// Reset:
//   rst (synchronous, active high) clears pc, registers, flags and status,
//   then a clearing pass zeros all 256 memory bytes, one byte a cycle,
//   with busy held high throughout.
// ----------------------------------------------------------------------------
module tiny_accumulator_cpu_step_top
  import tacs_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  req_t request,
  output logic done,
  output rsp_t result
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD,
    S_OP,
    S_B1,
    S_B2,
    S_EXEC,
    S_LDM
  } state_t;

  state_t state;

  // Architectural state
  logic [DATA_W-1:0] regs [REG_COUNT];
  logic [ADDR_W-1:0] pc;
  logic              zero_flag;
  logic              carry_flag;
  logic [1:0]        run_status;
  logic [DATA_W-1:0] read_byte;

  // Instruction holding registers
  logic [DATA_W-1:0] op;
  logic [DATA_W-1:0] b1;
  logic [DATA_W-1:0] b2;
  logic [DATA_W-1:0] opd;

  // Memory clearing pass after reset
  logic              clr_active;
  logic [ADDR_W-1:0] clr_addr;

  // RAM port
  logic              ram_we;
  logic [ADDR_W-1:0] ram_addr;
  logic [DATA_W-1:0] ram_wdata;
  logic [DATA_W-1:0] ram_rdata;

  // Datapath helpers
  logic                 accept;
  logic [ADDR_W-1:0]    pc_inc1;
  logic [ADDR_W-1:0]    pc_inc2;
  logic [ADDR_W-1:0]    pc_inc3;
  logic [REG_IDX_W-1:0] rf_raddr;
  logic [DATA_W-1:0]    rf_rdata;
  logic                 bad1;
  logic                 bad2;
  alu_op_t              alu_op;
  logic [DATA_W-1:0]    alu_b;
  logic [DATA_W-1:0]    alu_res;
  logic                 alu_carry;

  assign busy    = clr_active || (state != S_IDLE);
  assign accept  = start && !busy;
  assign pc_inc1 = pc + ADDR_W'(1);
  assign pc_inc2 = pc + ADDR_W'(2);
  assign pc_inc3 = pc + ADDR_W'(3);

  // Operand checks: any register number at or above the file size faults
  assign bad1 = (b1 >= DATA_W'(REG_COUNT));
  assign bad2 = (b2 >= DATA_W'(REG_COUNT));

  // One register read port: first operand while the last byte arrives,
  // second operand in the execute step
  assign rf_raddr = (state == S_B2) ? b1[REG_IDX_W-1:0] : b2[REG_IDX_W-1:0];
  assign rf_rdata = regs[rf_raddr];

  // Decode the ALU operation; inc and dec reuse add and sub with a one
  always_comb begin
    alu_op = ALU_PASS;
    alu_b  = rf_rdata;
    case (op)
      OP_ADD: alu_op = ALU_ADD;
      OP_SUB: alu_op = ALU_SUB;
      OP_AND: alu_op = ALU_AND;
      OP_OR:  alu_op = ALU_OR;
      OP_XOR: alu_op = ALU_XOR;
      OP_NOT: alu_op = ALU_NOT;
      OP_INC: begin
        alu_op = ALU_ADD;
        alu_b  = DATA_W'(1);
      end
      OP_DEC: begin
        alu_op = ALU_SUB;
        alu_b  = DATA_W'(1);
      end
      default: alu_op = ALU_PASS;
    endcase
  end

  tacs_alu u_alu (
    .op     (alu_op),
    .a      (opd),
    .b      (alu_b),
    .result (alu_res),
    .carry  (alu_carry)
  );

  // Steer the single RAM port
  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = pc;
    ram_wdata = request.write_byte;
    if (clr_active) begin
      ram_we    = 1'b1;
      ram_addr  = clr_addr;
      ram_wdata = '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept && (request.req_type == REQ_WRITE)) begin
            ram_we   = 1'b1;
            ram_addr = request.mem_address;
          end else if (accept && (request.req_type == REQ_READ)) begin
            ram_addr = request.mem_address;
          end
        end
        S_OP: ram_addr = pc_inc1;
        S_B1: ram_addr = pc_inc2;
        S_EXEC: begin
          ram_addr  = b2;
          ram_wdata = opd;
          ram_we    = (op == OP_STM) && !bad1;
        end
        default: ram_addr = pc;
      endcase
    end
  end

  tacs_ram #(
    .WIDTH (DATA_W),
    .DEPTH (MEM_DEPTH)
  ) u_mem (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // Sequencer, architectural state and registered outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      clr_active <= 1'b1;
      clr_addr   <= '0;
      done       <= 1'b0;
      pc         <= '0;
      zero_flag  <= 1'b0;
      carry_flag <= 1'b0;
      run_status <= ST_RUN;
      read_byte  <= '0;
      for (int i = 0; i < REG_COUNT; i++) begin
        regs[i] <= '0;
      end
    end else begin
      done <= 1'b0;
      if (clr_active) begin
        // sweep the memory to zero, stop after the last byte
        clr_addr <= clr_addr + ADDR_W'(1);
        if (clr_addr == '1) begin
          clr_active <= 1'b0;
        end
      end else begin
        case (state)
          S_IDLE: begin
            if (accept) begin
              read_byte <= '0;
              if (request.req_type == REQ_READ) begin
                state <= S_RD;
              end else if ((request.req_type == REQ_EXEC) && (run_status == ST_RUN)) begin
                state <= S_OP;
              end else begin
                // write, stopped CPU or unused code: answer at once
                done <= 1'b1;
              end
            end
          end
          S_RD: begin
            read_byte <= ram_rdata;
            done      <= 1'b1;
            state     <= S_IDLE;
          end
          S_OP: begin
            op    <= ram_rdata;
            state <= S_B1;
          end
          S_B1: begin
            b1    <= ram_rdata;
            state <= S_B2;
          end
          S_B2: begin
            b2    <= ram_rdata;
            opd   <= rf_rdata;
            state <= S_EXEC;
          end
          S_EXEC: begin
            state <= S_IDLE;
            done  <= 1'b1;
            case (op)
              OP_NOP: pc <= pc_inc1;
              OP_HLT: run_status <= ST_HALT;
              OP_JMP: pc <= b1;
              OP_JZ:  pc <= zero_flag ? b1 : pc_inc2;
              OP_JNZ: pc <= zero_flag ? pc_inc2 : b1;
              OP_JC:  pc <= carry_flag ? b1 : pc_inc2;
              OP_JNC: pc <= carry_flag ? pc_inc2 : b1;
              OP_LDI: begin
                if (bad1) begin
                  run_status <= ST_BADREG;
                end else begin
                  regs[b1[REG_IDX_W-1:0]] <= b2;
                  zero_flag <= (b2 == '0);
                  pc        <= pc_inc3;
                end
              end
              OP_LDM: begin
                if (bad1) begin
                  run_status <= ST_BADREG;
                end else begin
                  // hold off the result until the data byte is back
                  done  <= 1'b0;
                  state <= S_LDM;
                end
              end
              OP_STM: begin
                if (bad1) begin
                  run_status <= ST_BADREG;
                end else begin
                  pc <= pc_inc3;
                end
              end
              OP_INC, OP_DEC: begin
                if (bad1) begin
                  run_status <= ST_BADREG;
                end else begin
                  regs[b1[REG_IDX_W-1:0]] <= alu_res;
                  zero_flag  <= (alu_res == '0);
                  carry_flag <= alu_carry;
                  pc         <= pc_inc2;
                end
              end
              OP_NOT: begin
                if (bad1) begin
                  run_status <= ST_BADREG;
                end else begin
                  regs[b1[REG_IDX_W-1:0]] <= alu_res;
                  zero_flag <= (alu_res == '0);
                  pc        <= pc_inc2;
                end
              end
              OP_ADD, OP_SUB: begin
                if (bad1 || bad2) begin
                  run_status <= ST_BADREG;
                end else begin
                  regs[b1[REG_IDX_W-1:0]] <= alu_res;
                  zero_flag  <= (alu_res == '0);
                  carry_flag <= alu_carry;
                  pc         <= pc_inc3;
                end
              end
              OP_MOV, OP_AND, OP_OR, OP_XOR: begin
                if (bad1 || bad2) begin
                  run_status <= ST_BADREG;
                end else begin
                  regs[b1[REG_IDX_W-1:0]] <= alu_res;
                  zero_flag <= (alu_res == '0);
                  pc        <= pc_inc3;
                end
              end
              default: run_status <= ST_BADOP;
            endcase
          end
          S_LDM: begin
            regs[b1[REG_IDX_W-1:0]] <= ram_rdata;
            zero_flag <= (ram_rdata == '0);
            pc        <= pc_inc3;
            done      <= 1'b1;
            state     <= S_IDLE;
          end
          default: state <= S_IDLE;
        endcase
      end
    end
  end

  // Result beat: live architectural state plus the captured read byte
  assign result.status          = run_status;
  assign result.program_counter = pc;
  assign result.reg_a           = regs[0];
  assign result.reg_b           = regs[1];
  assign result.reg_c           = regs[2];
  assign result.reg_d           = regs[3];
  assign result.zero_flag       = zero_flag;
  assign result.carry_flag      = carry_flag;
  assign result.read_byte       = read_byte;

endmodule
